[rtl/ssmd_pkg.sv]
// shared types, operation codes and glyph functions for the seven-segment display driver
// no dependencies
`default_nettype none

package ssmd_pkg;

    localparam int NUM_DIGITS = 4;
    localparam int DIGIT_W    = 8;
    localparam int POS_W      = $clog2(NUM_DIGITS);

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h41;
    localparam logic [7:0] BLANK      = 8'hFF;

    typedef enum logic [2:0] {
        FUNC_CHAR   = 3'd0,
        FUNC_RAW    = 3'd1,
        FUNC_SET_DP = 3'd2,
        FUNC_CLR_DP = 3'd3,
        FUNC_HEX    = 3'd4,
        FUNC_DEC    = 3'd5,
        FUNC_SCAN   = 3'd6
    } func_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic exec;
    } ctl_t;

    // active-low glyph, letters case-insensitive
    function automatic logic [7:0] ssmd_glyph(input logic [7:0] ch);
        logic [7:0] c;
        logic [7:0] g;
        c = ch;
        if (ch >= "a" && ch <= "z")
        begin
            c = ch - 8'h20;
        end
        case (c)
            "-":           g = 8'hFE;
            "0", "O":      g = 8'h81;
            "1":           g = 8'hCF;
            "2", "Z":      g = 8'h92;
            "3":           g = 8'h86;
            "4":           g = 8'hCC;
            "5", "S":      g = 8'hA4;
            "6":           g = 8'hA0;
            "7":           g = 8'h8F;
            "8":           g = 8'h80;
            "9", "G":      g = 8'h84;
            "A":           g = 8'h88;
            "B":           g = 8'hE0;
            "C":           g = 8'hB1;
            "D":           g = 8'hC2;
            "E":           g = 8'hB0;
            "F":           g = 8'hB8;
            "H", "K", "X": g = 8'hC8;
            "I":           g = 8'hF9;
            "J":           g = 8'hC3;
            "L":           g = 8'hF1;
            "M":           g = 8'hAB;
            "N":           g = 8'hEA;
            "P":           g = 8'h98;
            "Q":           g = 8'h8C;
            "R":           g = 8'hFA;
            "T":           g = 8'hF0;
            "U":           g = 8'hC1;
            "V":           g = 8'hE3;
            "W":           g = 8'hD5;
            "Y":           g = 8'hC4;
            default:       g = BLANK;
        endcase
        return g;
    endfunction

    // new digit byte for a character write, point kept
    function automatic logic [7:0] ssmd_put(input logic [7:0] old, input logic [7:0] ch);
        logic [7:0] g;
        g = ssmd_glyph(ch);
        return {old[7] & g[7], g[6:0]};
    endfunction

    function automatic logic [7:0] ssmd_hex_ascii(input logic [3:0] v);
        logic [7:0] a;
        if (v <= 4'd9)
        begin
            a = ASCII_ZERO + {4'd0, v};
        end
        else
        begin
            a = ASCII_A + {4'd0, v} - 8'd10;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

[rtl/ssmd_cmd_if.sv]
// command channel: one operation word with valid/ready handshake
// no dependencies
`default_nettype none

interface ssmd_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [1:0] digit_index;
    logic [7:0] char_code;
    logic [15:0] hex_value;
    logic [7:0] dec_number;
    logic [1:0] dec_count;

    modport source (
        output valid, func, digit_index, char_code, hex_value, dec_number, dec_count,
        input  ready
    );
    modport sink (
        input  valid, func, digit_index, char_code, hex_value, dec_number, dec_count,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ssmd_drv_if.sv]
// drive channel: one result word per command with valid/ready handshake
// no dependencies
`default_nettype none

interface ssmd_drv_if;
    logic       valid;
    logic       ready;
    logic [7:0] segment_pattern;
    logic [1:0] active_digit;
    logic       drive_valid;

    modport source (
        output valid, segment_pattern, active_digit, drive_valid,
        input  ready
    );
    modport sink (
        input  valid, segment_pattern, active_digit, drive_valid,
        output ready
    );
endinterface

`default_nettype wire

[rtl/ssmd_ctrl.sv]
// controller: tracks the held command word and the output word, issues load/exec
// depends on ssmd_pkg
`default_nettype none

module ssmd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    output logic               cmd_ready,
    output logic               drv_valid,
    input  wire logic          drv_ready,
    output ssmd_pkg::ctl_t     ctl,
    output logic               busy
);
    import ssmd_pkg::*;

    typedef enum logic {
        S_EMPTY,
        S_LOADED
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   exec;
    logic   load;

    assign exec      = (state_reg == S_LOADED) && (!out_valid_reg || drv_ready);
    assign cmd_ready = (state_reg == S_EMPTY) || exec;
    assign load      = cmd_valid && cmd_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (drv_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (exec)
        begin
            out_valid_next = 1'b1;
        end
        case (state_reg)
            S_EMPTY:
            begin
                if (load)
                begin
                    state_next = S_LOADED;
                end
            end
            S_LOADED:
            begin
                if (exec && !load)
                begin
                    state_next = S_EMPTY;
                end
            end
            default:
            begin
                state_next = S_EMPTY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign drv_valid = out_valid_reg;
    assign ctl.load  = load;
    assign ctl.exec  = exec;
    assign busy      = (state_reg == S_LOADED);

endmodule

`default_nettype wire

[rtl/ssmd_datapath.sv]
// datapath: command register, digit store, scan position and output word register
// depends on ssmd_pkg
`default_nettype none

module ssmd_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ssmd_pkg::ctl_t         ctl,
    input  wire logic [2:0]             func,
    input  wire logic [1:0]             digit_index,
    input  wire logic [7:0]             char_code,
    input  wire logic [15:0]            hex_value,
    input  wire logic [7:0]             dec_number,
    input  wire logic [1:0]             dec_count,
    output logic [7:0]                  segment_pattern,
    output logic [1:0]                  active_digit,
    output logic                        drive_valid
);
    import ssmd_pkg::*;

    func_t          func_reg;
    logic [1:0]     idx_reg;
    logic [7:0]     char_reg;
    logic [15:0]    hex_reg;
    logic [7:0]     num_reg;
    logic [1:0]     cnt_reg;

    logic [DIGIT_W-1:0] store_reg  [NUM_DIGITS];
    logic [DIGIT_W-1:0] store_next [NUM_DIGITS];
    logic [POS_W-1:0]   scan_reg, scan_next;

    logic [7:0] seg_reg, seg_next;
    logic [1:0] act_reg, act_next;
    logic       dv_reg, dv_next;

    // decimal split by reciprocal multiply
    logic [15:0] prod10;
    logic [13:0] prod100;
    logic [4:0]  quot10;
    logic [1:0]  hund;
    logic [7:0]  units_w;
    logic [4:0]  tens_w;

    assign prod10  = 16'(num_reg) * 16'd205;
    assign prod100 = 14'(num_reg) * 14'd41;
    assign quot10  = prod10[15:11];
    assign hund    = prod100[13:12];
    assign units_w = num_reg - {quot10, 3'b000} - {2'b00, quot10, 1'b0};
    assign tens_w  = quot10 - {hund, 3'b000} - {2'b00, hund, 1'b0};

    always_comb
    begin
        for (int k = 0; k < NUM_DIGITS; k++)
        begin
            store_next[k] = store_reg[k];
        end
        scan_next = scan_reg;
        seg_next  = 8'd0;
        act_next  = 2'd0;
        dv_next   = 1'b0;
        case (func_reg)
            FUNC_CHAR:
            begin
                store_next[idx_reg] = ssmd_put(store_reg[idx_reg], char_reg);
            end
            FUNC_RAW:
            begin
                store_next[idx_reg] = {store_reg[idx_reg][7], char_reg[6:0]};
            end
            FUNC_SET_DP:
            begin
                store_next[idx_reg][7] = 1'b0;
            end
            FUNC_CLR_DP:
            begin
                store_next[idx_reg][7] = 1'b1;
            end
            FUNC_HEX:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    store_next[k] = ssmd_put(store_reg[k], ssmd_hex_ascii(hex_reg[4*k +: 4]));
                end
            end
            FUNC_DEC:
            begin
                store_next[0] = ssmd_put(store_reg[0], ASCII_ZERO + {4'd0, units_w[3:0]});
                if (cnt_reg > 2'd1)
                begin
                    store_next[1] = ssmd_put(store_reg[1], ASCII_ZERO + {4'd0, tens_w[3:0]});
                end
                if (cnt_reg > 2'd2)
                begin
                    store_next[2] = ssmd_put(store_reg[2], ASCII_ZERO + {6'd0, hund});
                end
            end
            FUNC_SCAN:
            begin
                seg_next = store_reg[scan_reg];
                act_next = scan_reg;
                dv_next  = 1'b1;
                if (scan_reg == '0)
                begin
                    scan_next = POS_W'(NUM_DIGITS - 1);
                end
                else
                begin
                    scan_next = scan_reg - 1'b1;
                end
            end
            default:
            begin
                seg_next = 8'd0;
            end
        endcase
    end

    // held command word
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            func_reg <= func_t'(func);
            idx_reg  <= digit_index;
            char_reg <= char_code;
            hex_reg  <= hex_value;
            num_reg  <= dec_number;
            cnt_reg  <= dec_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                store_reg[k] <= BLANK;
            end
            scan_reg <= POS_W'(NUM_DIGITS - 1);
        end
        else if (ctl.exec)
        begin
            for (int k = 0; k < NUM_DIGITS; k++)
            begin
                store_reg[k] <= store_next[k];
            end
            scan_reg <= scan_next;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (ctl.exec)
        begin
            seg_reg <= seg_next;
            act_reg <= act_next;
            dv_reg  <= dv_next;
        end
    end

    assign segment_pattern = seg_reg;
    assign active_digit    = act_reg;
    assign drive_valid     = dv_reg;

endmodule

`default_nettype wire

[rtl/seven_segment_mux_display_core.sv]
// Multiplexed seven-segment display driver, top level.
// Depends on ssmd_pkg, ssmd_cmd_if, ssmd_drv_if, ssmd_ctrl and ssmd_datapath.
//
// cmd carries one operation word: character, raw segments, set or clear point,
// hex value, decimal byte or scan tick. Every accepted word yields exactly one
// word on drv; only a scan tick has drive_valid set, with the active-low
// pattern and index of the digit to enable. Scanning runs from digit 3 down to
// 0 and wraps.
// A word is held in the command register until it is executed into the digit
// store and output register, so its result is offered on drv from the output
// register. Words are taken one per cycle while drv keeps up; the output
// register frees the command register as soon as it can be loaded.
// When drv stalls the output word holds, one further command waits in the
// command register and cmd.ready drops until drv takes its word.
// Reset blanks every digit (0xFF) and sets the scan position to 3; no clearing
// sweep is needed.
`default_nettype none

module seven_segment_mux_display_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    ssmd_cmd_if.sink    cmd,
    ssmd_drv_if.source  drv
);
    import ssmd_pkg::*;

    ctl_t ctl;
    logic busy;

    ssmd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .drv_valid (drv.valid),
        .drv_ready (drv.ready),
        .ctl       (ctl),
        .busy      (busy)
    );

    ssmd_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .func            (cmd.func),
        .digit_index     (cmd.digit_index),
        .char_code       (cmd.char_code),
        .hex_value       (cmd.hex_value),
        .dec_number      (cmd.dec_number),
        .dec_count       (cmd.dec_count),
        .segment_pattern (drv.segment_pattern),
        .active_digit    (drv.active_digit),
        .drive_valid     (drv.drive_valid)
    );

`ifndef SYNTHESIS
    // only back-pressure from drv may stall cmd
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (busy && drv.valid && !drv.ready))
        else $error("cmd stalled without drv back-pressure");

    // a held word reaches the output register once it is free
    a_held_word_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && !drv.valid) |=> drv.valid)
        else $error("held command word not executed");

    // non-scan results are all zero
    a_non_scan_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (drv.valid && !drv.drive_valid) |-> (drv.segment_pattern == 8'd0
            && drv.active_digit == 2'd0))
        else $error("non-scan result carries data");
`endif

endmodule

`default_nettype wire
